[rtl/rmvh_pkg.sv]
// rmvh_pkg: shared types and constants of the ranged multi-variable histogram
// depends on nothing; used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package rmvh_pkg;

	localparam int DEF_MAX_VARS   = 8;
	localparam int DEF_MAX_BINS   = 256;
	localparam int DEF_COUNT_BITS = 32;

	// request kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_USED  = 2'd0;
	localparam logic [1:0] ST_DROP  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PASS_MODE = 2'd0;
	localparam logic [1:0] CFG_NUM_VARS  = 2'd1;
	localparam logic [1:0] CFG_NUM_BINS  = 2'd2;

	typedef enum logic [1:0] {
		RT_OUT = 2'd0,
		RT_RD  = 2'd1,
		RT_MUL = 2'd2
	} route_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic mul;
		logic div;
		logic fix;
		logic rd;
		logic upd;
		logic clr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic   in_clear;
		route_t route;
		logic   div_last;
		logic   clr_last;
	} stat_t;

endpackage

`default_nettype wire

[rtl/ranged_multi_variable_histogram.sv]
// ranged_multi_variable_histogram: top level, range and bin histogram over tagged samples
// depends on rmvh_pkg, rmvh_ctrl and rmvh_dpath
// one request at a time: a range sample, drop or kind 3 goes from evaluation to the output register,
// a read or degenerate-range count adds a bin store read and update, and a counted sample adds a multiply,
// the restoring divider (one quotient bit per cycle) and a fix-up before these; a clear sweeps the bin store
// reset: config to range pass, 1 variable, 256 bins; then a clearing pass over all
// MAX_VARS*MAX_BINS entries of the bin store, in_ready low throughout
`timescale 1ns / 1ps
`default_nettype none

module ranged_multi_variable_histogram #(
	parameter int MAX_VARS   = rmvh_pkg::DEF_MAX_VARS,
	parameter int MAX_BINS   = rmvh_pkg::DEF_MAX_BINS,
	parameter int COUNT_BITS = rmvh_pkg::DEF_COUNT_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [8:0]         cfg_data,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [2:0]         var_index,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               sample_finite,
	input  wire logic [7:0]         bin_select,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [7:0]              bin_number,
	output logic [31:0]             bin_count,
	output logic signed [31:0]      range_min,
	output logic signed [31:0]      range_max
);
	import rmvh_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// controller: one-hot sequencer, owns in_ready and out_valid
	rmvh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: config, ranges, bin store, multiply and divide, output register
	rmvh_dpath #(
		.MAX_VARS   (MAX_VARS),
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.var_index     (var_index),
		.sample_value  (sample_value),
		.sample_finite (sample_finite),
		.bin_select    (bin_select),
		.cmd           (cmd),
		.st            (st),
		.status        (status),
		.bin_number    (bin_number),
		.bin_count     (bin_count),
		.range_min     (range_min),
		.range_max     (range_max)
	);

	// a taken request keeps the next one from being taken straight after it
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted on back-to-back cycles");

	// each controller state issues at most one command
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	// the output register is only reloaded when its result is gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	// no request taken while the clearing sweep runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !in_ready)
		else $error("request accepted during clearing sweep");

endmodule

`default_nettype wire

[rtl/rmvh_ctrl.sv]
// rmvh_ctrl: sequencing state machine of the histogram
// depends on rmvh_pkg; drives the datapath through cmd_t, watches stat_t
`timescale 1ns / 1ps
`default_nettype none

module rmvh_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire rmvh_pkg::stat_t st,
	output rmvh_pkg::cmd_t      cmd
);
	import rmvh_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CLR  = 9'b000000010,
		S_EVAL = 9'b000000100,
		S_MUL  = 9'b000001000,
		S_DIV  = 9'b000010000,
		S_FIX  = 9'b000100000,
		S_RD   = 9'b001000000,
		S_UPD  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   reply_q;
	logic   out_free;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = st.in_clear ? S_CLR : S_EVAL;
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_d = reply_q ? S_OUT : S_IDLE;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				case (st.route)
					RT_RD:   state_d = S_RD;
					RT_MUL:  state_d = S_MUL;
					default: state_d = S_OUT;
				endcase
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (st.div_last) state_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			reply_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) reply_q <= st.in_clear;
			if (cmd.load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/rmvh_dpath.sv]
// rmvh_dpath: config, range registers, bin store, divider and result registers
// depends on rmvh_pkg; commanded by rmvh_ctrl
`timescale 1ns / 1ps
`default_nettype none

module rmvh_dpath #(
	parameter int MAX_VARS   = rmvh_pkg::DEF_MAX_VARS,
	parameter int MAX_BINS   = rmvh_pkg::DEF_MAX_BINS,
	parameter int COUNT_BITS = rmvh_pkg::DEF_COUNT_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [8:0]         cfg_data,
	input  wire logic [1:0]         kind,
	input  wire logic [2:0]         var_index,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               sample_finite,
	input  wire logic [7:0]         bin_select,
	input  wire rmvh_pkg::cmd_t     cmd,
	output rmvh_pkg::stat_t         st,
	output logic [1:0]              status,
	output logic [7:0]              bin_number,
	output logic [31:0]             bin_count,
	output logic signed [31:0]      range_min,
	output logic signed [31:0]      range_max
);
	import rmvh_pkg::*;

	localparam int DEPTH = MAX_VARS * MAX_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int NBW   = $clog2(MAX_BINS + 1);
	localparam int QB    = NBW;
	localparam int CW    = (QB > 1) ? $clog2(QB) : 1;
	localparam int PW    = 33 + NBW;
	localparam int CB    = COUNT_BITS;
	localparam logic [CB-1:0] OUT_LIM = CB'(64'h0000_0000_FFFF_FFFF);

	// configuration
	logic       pass_mode_q;
	logic [3:0] num_vars_q;
	logic [8:0] num_bins_q;

	// captured request
	logic [1:0]         kind_q;
	logic [2:0]         var_q;
	logic signed [31:0] val_q;
	logic               fin_q;
	logic [7:0]         sel_q;

	// per-variable range
	logic signed [31:0] low_q  [MAX_VARS];
	logic signed [31:0] high_q [MAX_VARS];
	logic               seen_q [MAX_VARS];

	// bin store
	logic [CB-1:0] mem [DEPTH];
	logic [CB-1:0] rd_q;
	logic [AW-1:0] clr_q;

	// divider
	logic [32:0]     d_q, r_q;
	logic [PW-1:0]   rem_q, r_sh;
	logic [QB-1:0]   quo_q;
	logic [CW-1:0]   div_i_q;
	logic [BW-1:0]   bin_q;
	logic            rd_ok_q;

	// result holding
	logic [1:0]         res_status_q;
	logic [7:0]         res_bin_q;
	logic [31:0]        res_count_q;
	logic signed [31:0] res_min_q, res_max_q;

	logic [VW-1:0]      vix;
	logic               var_ok;
	logic [NBW-1:0]     nb;
	logic signed [31:0] lo, hi, new_lo, new_hi;
	logic               seen;
	logic [32:0]        d_c, r_c;
	logic [AW-1:0]      rd_addr;
	logic [CB-1:0]      cnt_new;
	logic [NBW-1:0]     q_fix;

	function automatic logic [31:0] sat32(input logic [CB-1:0] c);
		sat32 = (c > OUT_LIM) ? 32'hFFFF_FFFF : 32'(c);
	endfunction

	assign vix    = VW'(var_q);
	assign var_ok = (num_vars_q == 4'd0) ? (var_q == 3'd0)
		: (({1'b0, var_q} < num_vars_q) && (32'(var_q) < MAX_VARS));
	assign nb     = (num_bins_q == 9'd0 || 32'(num_bins_q) > MAX_BINS)
		? NBW'(MAX_BINS) : NBW'(num_bins_q);
	assign seen   = var_ok && seen_q[vix];
	assign lo     = seen ? low_q[vix]  : 32'sd0;
	assign hi     = seen ? high_q[vix] : 32'sd0;
	assign new_lo = (!seen_q[vix] || val_q < low_q[vix])  ? val_q : low_q[vix];
	assign new_hi = (!seen_q[vix] || val_q > high_q[vix]) ? val_q : high_q[vix];
	assign d_c    = {val_q[31], val_q} - {lo[31], lo};
	assign r_c    = {hi[31], hi} - {lo[31], lo};
	assign r_sh   = PW'(r_q) << div_i_q;
	assign q_fix  = (NBW'(quo_q) >= nb) ? (nb - NBW'(1)) : NBW'(quo_q);
	assign rd_addr = AW'(32'(vix) * MAX_BINS + 32'(bin_q));
	assign cnt_new = (rd_q == '1) ? rd_q : rd_q + CB'(1);

	always_comb begin
		st          = '0;
		st.in_clear = (kind == KIND_CLEAR);
		st.div_last = (div_i_q == '0);
		st.clr_last = (clr_q == AW'(DEPTH - 1));
		st.route    = RT_OUT;
		if (kind_q == KIND_READ) begin
			st.route = RT_RD;
		end else if (kind_q == KIND_SAMPLE && var_ok && fin_q && pass_mode_q) begin
			if (hi == lo) st.route = RT_RD;
			else if (!(val_q < lo || val_q > hi)) st.route = RT_MUL;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_mode_q <= 1'b0;
			num_vars_q  <= 4'd1;
			num_bins_q  <= 9'd256;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PASS_MODE: pass_mode_q <= cfg_data[0];
				CFG_NUM_VARS:  num_vars_q  <= cfg_data[3:0];
				CFG_NUM_BINS:  num_bins_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VARS; i++) begin
				low_q[i]  <= 32'sh7FFF_FFFF;
				high_q[i] <= 32'sh8000_0000;
				seen_q[i] <= 1'b0;
			end
		end else if (cmd.clr) begin
			for (int i = 0; i < MAX_VARS; i++) begin
				low_q[i]  <= 32'sh7FFF_FFFF;
				high_q[i] <= 32'sh8000_0000;
				seen_q[i] <= 1'b0;
			end
		end else if (cmd.eval && kind_q == KIND_SAMPLE && var_ok && fin_q && !pass_mode_q) begin
			low_q[vix]  <= new_lo;
			high_q[vix] <= new_hi;
			seen_q[vix] <= 1'b1;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr) clr_q <= st.clr_last ? '0 : clr_q + AW'(1);
	end

	// bin store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr) mem[clr_q] <= '0;
		else if (cmd.upd && kind_q == KIND_SAMPLE) mem[rd_addr] <= cnt_new;
		if (cmd.rd) rd_q <= mem[rd_addr];
	end

	// request capture, evaluation, divider and results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q       <= kind;
			var_q        <= var_index;
			val_q        <= sample_value;
			fin_q        <= sample_finite;
			sel_q        <= bin_select;
			res_status_q <= ST_CLEAR;
			res_bin_q    <= '0;
			res_count_q  <= '0;
			res_min_q    <= '0;
			res_max_q    <= '0;
		end
		if (cmd.eval) begin
			res_status_q <= ST_DROP;
			res_bin_q    <= '0;
			res_count_q  <= '0;
			res_min_q    <= '0;
			res_max_q    <= '0;
			bin_q        <= '0;
			rd_ok_q      <= 1'b0;
			d_q          <= d_c;
			r_q          <= r_c;
			if (kind_q == KIND_READ) begin
				res_status_q <= ST_READ;
				res_bin_q    <= sel_q;
				res_min_q    <= lo;
				res_max_q    <= hi;
				bin_q        <= BW'(sel_q);
				rd_ok_q      <= var_ok && (32'(sel_q) < 32'(nb));
			end else if (kind_q == KIND_SAMPLE && var_ok) begin
				res_min_q <= lo;
				res_max_q <= hi;
				if (fin_q && !pass_mode_q) begin
					res_status_q <= ST_USED;
					res_min_q    <= new_lo;
					res_max_q    <= new_hi;
				end else if (fin_q && st.route != RT_OUT) begin
					res_status_q <= ST_USED;
				end
			end
		end
		if (cmd.mul) begin
			rem_q   <= PW'(d_q) * PW'(nb);
			quo_q   <= '0;
			div_i_q <= CW'(QB - 1);
		end
		if (cmd.div) begin
			if (rem_q >= r_sh) begin
				rem_q          <= rem_q - r_sh;
				quo_q[div_i_q] <= 1'b1;
			end
			div_i_q <= div_i_q - CW'(1);
		end
		if (cmd.fix) begin
			bin_q     <= BW'(q_fix);
			res_bin_q <= 8'(q_fix);
		end
		if (cmd.upd) begin
			if (kind_q == KIND_SAMPLE) res_count_q <= sat32(cnt_new);
			else res_count_q <= rd_ok_q ? sat32(rd_q) : 32'd0;
		end
		if (cmd.load_out) begin
			status     <= res_status_q;
			bin_number <= res_bin_q;
			bin_count  <= res_count_q;
			range_min  <= res_min_q;
			range_max  <= res_max_q;
		end
	end

endmodule

`default_nettype wire
